// File: rtl/core/mlp_pkg.sv
// Shared types, sizes and constants of the latent predictor.
package mlp_pkg;

   localparam int MAX_LATENT  = 64;
   localparam int MAX_EMBED   = 16;
   localparam int MAX_ACTIONS = 16;
   localparam int W1_DEPTH    = (MAX_LATENT + MAX_EMBED) * MAX_LATENT;
   localparam int W2_DEPTH    = MAX_LATENT * MAX_LATENT;
   localparam int EMB_DEPTH   = MAX_ACTIONS * MAX_EMBED;

   localparam int LAT_AW = $clog2(MAX_LATENT);
   localparam int W1_AW  = $clog2(W1_DEPTH);
   localparam int W2_AW  = $clog2(W2_DEPTH);
   localparam int EMB_AW = $clog2(EMB_DEPTH);
   localparam int CNT_W  = $clog2(MAX_LATENT + MAX_EMBED + 1);

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [31:0] SEED_MUL = 32'd2654435761;
   localparam logic [31:0] LCG_A    = 32'd1664525;
   localparam logic [31:0] LCG_C    = 32'd1013904223;

   typedef enum logic [2:0] {
      KIND_LATENT  = 3'd0,
      KIND_W1      = 3'd1,
      KIND_W2      = 3'd2,
      KIND_EMBED   = 3'd3,
      KIND_PREDICT = 3'd4
   } kind_type;

   localparam logic [1:0] STAT_TRAINED    = 2'd0;
   localparam logic [1:0] STAT_FALLBACK   = 2'd1;
   localparam logic [1:0] STAT_BAD_ACTION = 2'd2;

   localparam logic [1:0] CSR_LATENT_SIZE   = 2'd0;
   localparam logic [1:0] CSR_EMBED_SIZE    = 2'd1;
   localparam logic [1:0] CSR_ACTION_LIMIT  = 2'd2;
   localparam logic [1:0] CSR_WEIGHTS_VALID = 2'd3;

   typedef struct packed {
      logic [6:0] latent_size;
      logic [4:0] embed_size;
      logic [4:0] action_limit;
      logic       weights_valid;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [12:0]        index;
      logic signed [15:0] value;
      logic [7:0]         action;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

endpackage

// File: rtl/core/mlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mlp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// File: rtl/core/mlp_front.sv
// Front end: accepts request words, drops unknown kinds, queues the rest.
module mlp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [2:0]         req_kind,
   input  logic [12:0]        req_index,
   input  logic signed [15:0] req_value,
   input  logic [7:0]         req_action,
   input  logic               pop,
   output logic               busy,
   output mlp_pkg::queue_type q
);
   import mlp_pkg::*;

   cmd_type        qmem_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;
   logic           push;
   logic           do_pop;
   cmd_type        cmd_word;

   assign busy = (count_ff == (QAW + 1)'(QDEPTH));
   assign push = start && !busy &&
                 (req_kind inside {KIND_LATENT, KIND_W1, KIND_W2, KIND_EMBED, KIND_PREDICT});
   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      cmd_word.kind   = kind_type'(req_kind);
      cmd_word.index  = req_index;
      cmd_word.value  = req_value;
      cmd_word.action = req_action;
      q.valid         = (count_ff != '0);
      q.cmd           = qmem_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         qmem_ff[wr_ptr_ff] <= cmd_word;
      end
   end

endmodule

// File: rtl/core/mlp_back.sv
// Back end: store writes, MAC walk of both layers, fallback bias, normalize and emit.
module mlp_back (
   input  logic               clock,
   input  logic               reset,
   input  mlp_pkg::cfg_type   cfg,
   input  mlp_pkg::queue_type q,
   output logic               pop,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_element_value,
   output logic [5:0]         rsp_element_index,
   output logic               rsp_last,
   output logic [1:0]         rsp_status
);
   import mlp_pkg::*;

   localparam int ACC_W  = 56;
   localparam int SQ_W   = 56;
   localparam int SQRT_W = 28;
   localparam int REM_W  = 40;
   localparam int DIV_W  = 42;
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7fffffff);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

   typedef enum logic [4:0] {
      S_IDLE, S_L1, S_L1_DRAIN, S_L2, S_L2_DRAIN, S_FB_RD, S_FB_WR,
      S_MAX, S_MAX_DRAIN, S_SHIFT, S_SQ, S_SQ_DRAIN, S_SQRT,
      S_OUT_RD, S_OUT_WAIT, S_OUT_DIV
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     i_ff, i_in, j_ff, j_in;
   logic [W1_AW-1:0]     w_addr_ff, w_addr_in;
   logic [EMB_AW-1:0]    emb_addr_ff, emb_addr_in, emb_base_ff, emb_base_in;
   logic [1:0]           status_ff, status_in;
   logic [31:0]          seed_ff, seed_in;
   logic [31:0]          m_ff, m_in;
   logic [3:0]           s_ff, s_in;
   logic [SQ_W-1:0]      sum_ff, sum_in, xr_ff, xr_in, r_ff, r_in, bit_ff, bit_in;
   logic [SQRT_W-1:0]    n_ff, n_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [14:0]          qt_ff, qt_in;
   logic [3:0]           k_ff, k_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_in, rsp_last_in;
   logic signed [15:0]   rsp_value_in;
   logic [5:0]           rsp_index_in;
   logic [1:0]           rsp_status_in;

   // limits from the registers
   logic [CNT_W-1:0] lim_l, lim_e, lim_a, lim_le;

   // memories
   logic                 lat_we, w1_we, w2_we, emb_we, hid_we, raw_we;
   logic [15:0]          lat_rdata, w1_rdata, w2_rdata, emb_rdata;
   logic [31:0]          hid_rdata, raw_rdata, hid_wdata, raw_wdata;
   logic [LAT_AW-1:0]    raw_waddr;

   // MAC pipeline
   logic                 iss_v, iss_first, iss_last, iss_emb, iss_l2;
   logic                 p1_v_ff, p1_first_ff, p1_last_ff, p1_emb_ff, p1_l2_ff;
   logic [LAT_AW-1:0]    p1_j_ff, p2_j_ff, res_j_ff;
   logic                 p2_v_ff, p2_first_ff, p2_last_ff, p2_l2_ff;
   logic signed [47:0]   p2_prod_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_sum, res_val_ff, res_sh;
   logic                 res_v_ff, res_l2_ff;
   logic signed [31:0]   mac_x, post_val;
   logic signed [15:0]   mac_w, lat_s, emb_s;

   // read stream for normalization
   logic                 rd_iss, rd_sq;
   logic                 rd_v_ff, rd_sq_ff, v_v_ff, sq_v_ff;
   logic signed [24:0]   v_ff, v_cur;
   logic signed [49:0]   sq_ff;
   logic signed [31:0]   raw_s;
   logic [31:0]          raw_abs;
   logic [24:0]          mag;

   // fallback and divide
   logic signed [9:0]    fb_c;
   logic signed [22:0]   fb_p;
   logic [DIV_W-1:0]     trial;
   logic                 ge;
   logic [14:0]          qt_fin;
   logic [15:0]          qt_ext;
   logic [SQ_W-1:0]      rb;
   logic                 at_last;

   always_comb begin
      lim_l = (cfg.latent_size == '0) ? CNT_W'(1) :
              ((CNT_W'(cfg.latent_size) > CNT_W'(MAX_LATENT)) ? CNT_W'(MAX_LATENT)
                                                               : CNT_W'(cfg.latent_size));
      lim_e = (CNT_W'(cfg.embed_size) > CNT_W'(MAX_EMBED)) ? CNT_W'(MAX_EMBED)
                                                           : CNT_W'(cfg.embed_size);
      lim_a = (CNT_W'(cfg.action_limit) > CNT_W'(MAX_ACTIONS)) ? CNT_W'(MAX_ACTIONS)
                                                               : CNT_W'(cfg.action_limit);
      lim_le = lim_l + lim_e;
   end

   mlp_ram #(.WIDTH(16), .DEPTH(MAX_LATENT)) u_lat (
      .clock(clock), .we(lat_we), .waddr(q.cmd.index[LAT_AW-1:0]), .wdata(q.cmd.value),
      .raddr(i_ff[LAT_AW-1:0]), .rdata(lat_rdata));
   mlp_ram #(.WIDTH(16), .DEPTH(W1_DEPTH)) u_w1 (
      .clock(clock), .we(w1_we), .waddr(q.cmd.index[W1_AW-1:0]), .wdata(q.cmd.value),
      .raddr(w_addr_ff), .rdata(w1_rdata));
   mlp_ram #(.WIDTH(16), .DEPTH(W2_DEPTH)) u_w2 (
      .clock(clock), .we(w2_we), .waddr(q.cmd.index[W2_AW-1:0]), .wdata(q.cmd.value),
      .raddr(w_addr_ff[W2_AW-1:0]), .rdata(w2_rdata));
   mlp_ram #(.WIDTH(16), .DEPTH(EMB_DEPTH)) u_emb (
      .clock(clock), .we(emb_we), .waddr(q.cmd.index[EMB_AW-1:0]), .wdata(q.cmd.value),
      .raddr(emb_addr_ff), .rdata(emb_rdata));
   mlp_ram #(.WIDTH(32), .DEPTH(MAX_LATENT)) u_hid (
      .clock(clock), .we(hid_we), .waddr(res_j_ff), .wdata(hid_wdata),
      .raddr(i_ff[LAT_AW-1:0]), .rdata(hid_rdata));
   mlp_ram #(.WIDTH(32), .DEPTH(MAX_LATENT)) u_raw (
      .clock(clock), .we(raw_we), .waddr(raw_waddr), .wdata(raw_wdata),
      .raddr(i_ff[LAT_AW-1:0]), .rdata(raw_rdata));

   // datapath terms
   always_comb begin
      lat_s   = lat_rdata;
      emb_s   = emb_rdata;
      mac_x   = p1_l2_ff ? $signed(hid_rdata) : (p1_emb_ff ? 32'(emb_s) : 32'(lat_s));
      mac_w   = p1_l2_ff ? $signed(w2_rdata) : $signed(w1_rdata);
      acc_sum = (p2_first_ff ? '0 : acc_ff) + ACC_W'(p2_prod_ff);
      res_sh  = res_val_ff >>> 12;
      if (res_sh > SAT_HI) begin
         post_val = 32'(SAT_HI);
      end else if (res_sh < SAT_LO) begin
         post_val = 32'(SAT_LO);
      end else begin
         post_val = 32'(res_sh);
      end
      hid_wdata = post_val[31] ? 32'd0 : post_val;
      raw_s   = $signed(raw_rdata);
      raw_abs = raw_s[31] ? 32'(-raw_s) : raw_rdata;
      v_cur   = 25'(raw_s >>> s_ff);
      mag     = v_cur[24] ? 25'(-v_cur) : v_cur;
      fb_c    = $signed({2'b00, seed_ff[7:0]}) - 10'sd128;
      fb_p    = fb_c * 23'sd1638;
      trial   = DIV_W'(n_ff) << k_ff;
      ge      = (DIV_W'(rem_ff) >= trial);
      qt_fin  = ge ? (qt_ff | (15'd1 << k_ff)) : qt_ff;
      qt_ext  = {1'b0, qt_fin};
      rb      = r_ff + bit_ff;
      at_last = (i_ff == lim_l - 1'b1);
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      w_addr_in     = w_addr_ff;
      emb_addr_in   = emb_addr_ff;
      emb_base_in   = emb_base_ff;
      status_in     = status_ff;
      seed_in       = seed_ff;
      m_in          = m_ff;
      s_in          = s_ff;
      sum_in        = sum_ff;
      xr_in         = xr_ff;
      r_in          = r_ff;
      bit_in        = bit_ff;
      n_in          = n_ff;
      rem_in        = rem_ff;
      qt_in         = qt_ff;
      k_in          = k_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_element_value;
      rsp_index_in  = rsp_element_index;
      rsp_last_in   = rsp_last;
      rsp_status_in = rsp_status;
      pop           = 1'b0;
      lat_we        = 1'b0;
      w1_we         = 1'b0;
      w2_we         = 1'b0;
      emb_we        = 1'b0;
      hid_we        = res_v_ff && !res_l2_ff;
      raw_we        = res_v_ff && res_l2_ff;
      raw_waddr     = res_j_ff;
      raw_wdata     = post_val;
      iss_v         = 1'b0;
      iss_first     = (i_ff == '0);
      iss_last      = 1'b0;
      iss_emb       = (i_ff >= lim_l);
      iss_l2        = 1'b0;
      rd_iss        = 1'b0;
      rd_sq         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (q.valid) begin
               pop = 1'b1;
               case (q.cmd.kind)
                  KIND_LATENT: lat_we = (32'(q.cmd.index) < MAX_LATENT);
                  KIND_W1:     w1_we  = (32'(q.cmd.index) < W1_DEPTH);
                  KIND_W2:     w2_we  = (32'(q.cmd.index) < W2_DEPTH);
                  KIND_EMBED:  emb_we = (32'(q.cmd.index) < EMB_DEPTH);
                  KIND_PREDICT: begin
                     i_in        = '0;
                     j_in        = '0;
                     w_addr_in   = '0;
                     emb_base_in = EMB_AW'(16'(q.cmd.action) * 16'(lim_e));
                     emb_addr_in = EMB_AW'(16'(q.cmd.action) * 16'(lim_e));
                     m_in        = '0;
                     s_in        = '0;
                     sum_in      = '0;
                     seed_in     = 32'(q.cmd.action) * SEED_MUL;
                     if (q.cmd.action >= 8'(lim_a)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_value_in  = '0;
                        rsp_index_in  = '0;
                        rsp_last_in   = 1'b1;
                        rsp_status_in = STAT_BAD_ACTION;
                     end else if (cfg.weights_valid) begin
                        status_in = STAT_TRAINED;
                        state_in  = S_L1;
                     end else begin
                        status_in = STAT_FALLBACK;
                        state_in  = S_FB_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_L1, S_L2: begin
            iss_v    = 1'b1;
            iss_l2   = (state_ff == S_L2);
            iss_last = (i_ff == ((state_ff == S_L2) ? lim_l : lim_le) - 1'b1);
            if (iss_last) begin
               i_in        = '0;
               j_in        = j_ff + 1'b1;
               w_addr_in   = W1_AW'(j_ff) + 1'b1;
               emb_addr_in = emb_base_ff;
               if (j_ff == lim_l - 1'b1) begin
                  state_in = (state_ff == S_L2) ? S_L2_DRAIN : S_L1_DRAIN;
               end
            end else begin
               i_in      = i_ff + 1'b1;
               w_addr_in = w_addr_ff + W1_AW'(lim_l);
               if (iss_emb) begin
                  emb_addr_in = emb_addr_ff + 1'b1;
               end
            end
         end
         S_L1_DRAIN, S_L2_DRAIN: begin
            if (!p1_v_ff && !p2_v_ff && !res_v_ff) begin
               i_in      = '0;
               j_in      = '0;
               w_addr_in = '0;
               state_in  = (state_ff == S_L1_DRAIN) ? S_L2 : S_MAX;
            end
         end
         S_FB_RD: begin
            seed_in  = seed_ff * LCG_A + LCG_C;
            state_in = S_FB_WR;
         end
         S_FB_WR: begin
            raw_we    = 1'b1;
            raw_waddr = i_ff[LAT_AW-1:0];
            raw_wdata = 32'(lat_s) + 32'(fb_p >>> 10);
            if (at_last) begin
               i_in     = '0;
               state_in = S_MAX;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_FB_RD;
            end
         end
         S_MAX, S_SQ: begin
            rd_iss = 1'b1;
            rd_sq  = (state_ff == S_SQ);
            if (at_last) begin
               i_in     = '0;
               state_in = (state_ff == S_SQ) ? S_SQ_DRAIN : S_MAX_DRAIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_MAX_DRAIN: begin
            if (!rd_v_ff) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (m_ff >= 32'd16777216) begin
               m_in = m_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               i_in     = '0;
               state_in = S_SQ;
            end
         end
         S_SQ_DRAIN: begin
            if (!rd_v_ff && !v_v_ff && !sq_v_ff) begin
               xr_in    = sum_ff;
               r_in     = '0;
               bit_in   = SQ_W'(1) << 54;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (bit_ff == '0) begin
               n_in     = SQRT_W'(r_ff);
               i_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               if (xr_ff >= rb) begin
                  xr_in = xr_ff - rb;
                  r_in  = (r_ff >> 1) + bit_ff;
               end else begin
                  r_in  = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_OUT_RD: state_in = S_OUT_WAIT;
         S_OUT_WAIT: begin
            neg_in = v_cur[24];
            if (n_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_index_in  = i_ff[5:0];
               rsp_last_in   = at_last;
               rsp_status_in = status_ff;
               i_in          = i_ff + 1'b1;
               state_in      = at_last ? S_IDLE : S_OUT_RD;
            end else begin
               rem_in   = REM_W'({mag, 14'b0}) + REM_W'(n_ff >> 1);
               qt_in    = '0;
               k_in     = 4'd14;
               state_in = S_OUT_DIV;
            end
         end
         S_OUT_DIV: begin
            qt_in = qt_fin;
            if (ge) begin
               rem_in = REM_W'(DIV_W'(rem_ff) - trial);
            end
            if (k_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = neg_ff ? $signed(-qt_ext) : $signed(qt_ext);
               rsp_index_in  = i_ff[5:0];
               rsp_last_in   = at_last;
               rsp_status_in = status_ff;
               i_in          = i_ff + 1'b1;
               state_in      = at_last ? S_IDLE : S_OUT_RD;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rd_v_ff && !rd_sq_ff && (raw_abs > m_ff)) begin
         m_in = raw_abs;
      end
      if (sq_v_ff) begin
         sum_in = sum_ff + SQ_W'(sq_ff[48:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= rsp_valid_in;
      end
      i_ff              <= i_in;
      j_ff              <= j_in;
      w_addr_ff         <= w_addr_in;
      emb_addr_ff       <= emb_addr_in;
      emb_base_ff       <= emb_base_in;
      status_ff         <= status_in;
      seed_ff           <= seed_in;
      m_ff              <= m_in;
      s_ff              <= s_in;
      sum_ff            <= sum_in;
      xr_ff             <= xr_in;
      r_ff              <= r_in;
      bit_ff            <= bit_in;
      n_ff              <= n_in;
      rem_ff            <= rem_in;
      qt_ff             <= qt_in;
      k_ff              <= k_in;
      neg_ff            <= neg_in;
      rsp_element_value <= rsp_value_in;
      rsp_element_index <= rsp_index_in;
      rsp_last          <= rsp_last_in;
      rsp_status        <= rsp_status_in;
   end

   // MAC and read-stream pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         res_v_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
         v_v_ff   <= 1'b0;
         sq_v_ff  <= 1'b0;
      end else begin
         p1_v_ff  <= iss_v;
         p2_v_ff  <= p1_v_ff;
         res_v_ff <= p2_v_ff && p2_last_ff;
         rd_v_ff  <= rd_iss;
         v_v_ff   <= rd_v_ff && rd_sq_ff;
         sq_v_ff  <= v_v_ff;
      end
      p1_first_ff <= iss_first;
      p1_last_ff  <= iss_last;
      p1_emb_ff   <= iss_emb;
      p1_l2_ff    <= iss_l2;
      p1_j_ff     <= j_ff[LAT_AW-1:0];
      p2_first_ff <= p1_first_ff;
      p2_last_ff  <= p1_last_ff;
      p2_l2_ff    <= p1_l2_ff;
      p2_j_ff     <= p1_j_ff;
      p2_prod_ff  <= 48'(mac_x * mac_w);
      if (p2_v_ff) begin
         acc_ff <= acc_sum;
      end
      res_val_ff  <= acc_sum;
      res_l2_ff   <= p2_l2_ff;
      res_j_ff    <= p2_j_ff;
      rd_sq_ff    <= rd_sq;
      v_ff        <= v_cur;
      sq_ff       <= v_ff * v_ff;
   end

endmodule

// File: rtl/core/two_layer_mlp_latent_predictor.sv
// Top level of the two-layer MLP latent predictor.
//
// Request channel: a word is taken at a clock edge with start high and busy
// low. Kinds 0..3 write one Q4.12 word into the latent, W1, W2 or embedding
// store; kind 4 runs a prediction for req_action; kinds 5..7 are dropped.
// Words pass through a four-entry queue, so busy rises only when it fills.
// The back end does a store write from its idle state.
// A prediction emits one rsp_valid strobe per element, index 0 to L-1, last
// set on the final one; an action at or above the limit gives one status 2
// word. Trained path: (L+E)*L + L*L products in the shared multiply-
// accumulate (one product per cycle, W1 and W2 ports), then max and sum
// of squares, the square root and a serial divide per element.
// Fallback path: a bias per element, then the same normalize tail.
// Results cannot be held off: each strobe lasts one cycle.
// Reset (synchronous) empties the queue and loads the register defaults;
// store contents are undefined until written.
module two_layer_mlp_latent_predictor (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_kind,
   input  logic [12:0]        req_index,
   input  logic signed [15:0] req_value,
   input  logic [7:0]         req_action,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_element_value,
   output logic [5:0]         rsp_element_index,
   output logic               rsp_last,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_wdata
);
   import mlp_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   queue_type q;
   logic      pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LATENT_SIZE:   cfg_in.latent_size   = csr_wdata;
            CSR_EMBED_SIZE:    cfg_in.embed_size    = csr_wdata[4:0];
            CSR_ACTION_LIMIT:  cfg_in.action_limit  = csr_wdata[4:0];
            CSR_WEIGHTS_VALID: cfg_in.weights_valid = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.latent_size   <= 7'd64;
         cfg_ff.embed_size    <= 5'd16;
         cfg_ff.action_limit  <= 5'd16;
         cfg_ff.weights_valid <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlp_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_kind(req_kind),
      .req_index(req_index), .req_value(req_value), .req_action(req_action),
      .pop(pop), .busy(busy), .q(q));

   mlp_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q(q), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_element_value(rsp_element_value),
      .rsp_element_index(rsp_element_index), .rsp_last(rsp_last),
      .rsp_status(rsp_status));

   a_bad_action_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_BAD_ACTION) |->
         rsp_last && (rsp_element_index == '0) && (rsp_element_value == '0))
      else $error("bad-action word not a single zero word");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_element_value <= 16'sd16384) && (rsp_element_value >= -16'sd16384))
      else $error("normalized element above unit magnitude");

   a_trained_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_TRAINED) |-> cfg_ff.weights_valid)
      else $error("trained status without weights valid");

endmodule

// File: tb/tb_two_layer_mlp_latent_predictor.sv
// Self-checking testbench for the two-layer MLP latent predictor.
`timescale 1ns / 100ps

module tb_two_layer_mlp_latent_predictor;
   import mlp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 64;

   // small trained net: store prefixes that it reads
   localparam int FILL_L   = 2;
   localparam int FILL_E   = 1;
   localparam int FILL_A   = 2;
   localparam int FILL_W1  = (FILL_L + FILL_E) * FILL_L;
   localparam int FILL_W2  = FILL_L * FILL_L;
   localparam int FILL_EMB = FILL_A * FILL_E;

   typedef struct {
      logic signed [15:0] value;
      logic [5:0]         index;
      logic               last;
      logic [1:0]         status;
   } element_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_kind = '0;
   logic [12:0]        req_index = '0;
   logic signed [15:0] req_value = '0;
   logic [7:0]         req_action = '0;
   logic               rsp_valid;
   logic signed [15:0] rsp_element_value;
   logic [5:0]         rsp_element_index;
   logic               rsp_last;
   logic [1:0]         rsp_status;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [6:0]         csr_wdata = '0;

   two_layer_mlp_latent_predictor u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_index(req_index), .req_value(req_value),
      .req_action(req_action), .rsp_valid(rsp_valid),
      .rsp_element_value(rsp_element_value), .rsp_element_index(rsp_element_index),
      .rsp_last(rsp_last), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow state
   logic [6:0] sh_latent_size = 7'd64;
   logic [4:0] sh_embed_size = 5'd16;
   logic [4:0] sh_action_limit = 5'd16;
   logic       sh_weights_valid = 1'b0;
   logic signed [15:0] sh_latent [MAX_LATENT];
   logic signed [15:0] sh_w1 [W1_DEPTH];
   logic signed [15:0] sh_w2 [W2_DEPTH];
   logic signed [15:0] sh_emb [EMB_DEPTH];
   int  sh_hidden [MAX_LATENT];
   int  sh_raw [MAX_LATENT];

   element_type pending_elems[$];
   int  mismatches = 0;
   int  n_predicts = 0;
   int  n_results = 0;
   int  idle_cycles_seen = 0;
   bit  idle_on = 1'b1;
   bit  accepted_now;

   function automatic int clip32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return int'(x);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic void predict_elements(logic [2:0] kind, logic [12:0] idx,
                                            logic signed [15:0] val, logic [7:0] act);
      int L, E, A, i, j, s;
      longint acc, m, v, q, b;
      longint unsigned sum, n, mag;
      logic [31:0] seed;
      logic [1:0] st;
      element_type w;
      case (kind)
         KIND_LATENT: begin if (idx < MAX_LATENT) sh_latent[idx[LAT_AW-1:0]] = val; return; end
         KIND_W1:     begin if (idx < W1_DEPTH) sh_w1[idx] = val; return; end
         KIND_W2:     begin if (idx < W2_DEPTH) sh_w2[idx[W2_AW-1:0]] = val; return; end
         KIND_EMBED:  begin if (idx < EMB_DEPTH) sh_emb[idx[EMB_AW-1:0]] = val; return; end
         KIND_PREDICT: ;
         default: return;
      endcase
      n_predicts++;
      L = sh_latent_size < 1 ? 1 : (sh_latent_size > MAX_LATENT ? MAX_LATENT : sh_latent_size);
      E = sh_embed_size > MAX_EMBED ? MAX_EMBED : sh_embed_size;
      A = sh_action_limit > MAX_ACTIONS ? MAX_ACTIONS : sh_action_limit;
      if (act >= A) begin
         w.value = '0; w.index = '0; w.last = 1'b1; w.status = STAT_BAD_ACTION;
         pending_elems.push_back(w);
         return;
      end
      if (sh_weights_valid) begin
         st = STAT_TRAINED;
         for (j = 0; j < L; j++) begin
            acc = 0;
            for (i = 0; i < L + E; i++) begin
               if (i < L) acc += longint'(sh_latent[i]) * longint'(sh_w1[i * L + j]);
               else acc += longint'(sh_emb[act * E + (i - L)]) * longint'(sh_w1[i * L + j]);
            end
            sh_hidden[j] = clip32(acc >>> 12);
            if (sh_hidden[j] < 0) sh_hidden[j] = 0;
         end
         for (j = 0; j < L; j++) begin
            acc = 0;
            for (i = 0; i < L; i++)
               acc += longint'(sh_hidden[i]) * longint'(sh_w2[i * L + j]);
            sh_raw[j] = clip32(acc >>> 12);
         end
      end else begin
         st = STAT_FALLBACK;
         seed = {24'd0, act} * SEED_MUL;
         for (i = 0; i < L; i++) begin
            seed = seed * LCG_A + LCG_C;
            b = (longint'(seed & 32'hff) - 128) * 1638;
            sh_raw[i] = int'(longint'(sh_latent[i]) + (b >>> 10));
         end
      end
      m = 0;
      for (i = 0; i < L; i++) begin
         v = sh_raw[i];
         if (v < 0) v = -v;
         if (v > m) m = v;
      end
      s = 0;
      while ((m >> s) >= (64'sd1 << 24)) s++;
      sum = 0;
      for (i = 0; i < L; i++) begin
         v = longint'(sh_raw[i]) >>> s;
         sum += longint'(v * v);
      end
      n = int_sqrt(sum);
      for (i = 0; i < L; i++) begin
         q = 0;
         if (n != 0) begin
            v = longint'(sh_raw[i]) >>> s;
            mag = v < 0 ? -v : v;
            mag = (mag * 16384 + n / 2) / n;
            q = v < 0 ? -longint'(mag) : longint'(mag);
         end
         w.value = q[15:0]; w.index = i[5:0]; w.last = (i == L - 1); w.status = st;
         pending_elems.push_back(w);
      end
   endfunction

   task automatic note_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // result checker
   always @(posedge clock) begin
      element_type e;
      if (!reset && rsp_valid) begin
         n_results++;
         if (pending_elems.size() == 0) begin
            note_mismatch("unexpected result word");
         end else begin
            e = pending_elems.pop_front();
            if (rsp_element_value !== e.value || rsp_element_index !== e.index ||
                rsp_last !== e.last || rsp_status !== e.status)
               note_mismatch($sformatf("got v=%0d i=%0d l=%0b s=%0d exp v=%0d i=%0d l=%0b s=%0d",
                  rsp_element_value, rsp_element_index, rsp_last, rsp_status,
                  e.value, e.index, e.last, e.status));
         end
      end
   end

   // watchdog on cycles with no accepted word and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles_seen <= 0;
      else idle_cycles_seen <= idle_cycles_seen + 1;
      if (idle_cycles_seen >= WATCHDOG_LIMIT) begin
         $display("timeout: no progress");
         $display("tb_two_layer_mlp_latent_predictor: errors");
         $finish;
      end
   end

   task automatic send_word(logic [2:0] kind, logic [12:0] idx,
                            logic signed [15:0] val, logic [7:0] act);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < 11) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_kind = kind; req_index = idx; req_value = val; req_action = act;
      start = 1'b1;
      accepted_now = 1'b0;
      while (!accepted_now) begin
         @(posedge clock);
         accepted_now = !busy;
      end
      predict_elements(kind, idx, val, act);
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] data);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_LATENT_SIZE:   sh_latent_size = data;
         CSR_EMBED_SIZE:    sh_embed_size = data[4:0];
         CSR_ACTION_LIMIT:  sh_action_limit = data[4:0];
         CSR_WEIGHTS_VALID: sh_weights_valid = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(int ls, int es, int al, int wv);
      drain();
      write_csr(CSR_LATENT_SIZE, 7'(ls));
      write_csr(CSR_EMBED_SIZE, 7'(es));
      write_csr(CSR_ACTION_LIMIT, 7'(al));
      write_csr(CSR_WEIGHTS_VALID, 7'(wv));
   endtask

   // whole latent store, plus the prefixes that the small trained net reads
   task automatic fill_stores;
      int a;
      for (a = 0; a < MAX_LATENT; a++)
         send_word(KIND_LATENT, 13'(a), 16'($urandom), '0);
      for (a = 0; a < FILL_EMB; a++)
         send_word(KIND_EMBED, 13'(a), 16'($urandom), '0);
      for (a = 0; a < FILL_W1; a++)
         send_word(KIND_W1, 13'(a), 16'($urandom), '0);
      for (a = 0; a < FILL_W2; a++)
         send_word(KIND_W2, 13'(a), 16'($urandom), '0);
   endtask

   task automatic test_defaults_fallback;
      send_word(KIND_PREDICT, '0, '0, '0);
      send_word(KIND_PREDICT, '0, '0, 8'd15);
      send_word(KIND_PREDICT, '0, '0, 8'd16);
      send_word(KIND_PREDICT, 13'h1fff, 16'sh8000, 8'hff);
   endtask

   task automatic test_trained_small;
      set_config(FILL_L, FILL_E, FILL_A, 1);
      send_word(KIND_PREDICT, '0, '0, 8'd0);
      send_word(KIND_PREDICT, '0, '0, 8'd1);
      send_word(KIND_PREDICT, '0, '0, 8'd2);
   endtask

   task automatic test_clamps;
      set_config(127, 31, 31, 0);
      send_word(KIND_PREDICT, '0, '0, 8'd15);
      send_word(KIND_PREDICT, '0, '0, 8'd16);
      set_config(0, 0, 0, 0);
      send_word(KIND_PREDICT, '0, '0, '0);
      set_config(0, 0, 1, 0);
      send_word(KIND_PREDICT, '0, '0, '0);
   endtask

   task automatic test_zero_and_extremes;
      set_config(1, 0, 1, 1);
      send_word(KIND_LATENT, '0, 16'sd4096, '0);
      send_word(KIND_W1, '0, -16'sd4096, '0);
      send_word(KIND_PREDICT, '0, '0, '0);
      send_word(KIND_LATENT, '0, 16'sh8000, '0);
      send_word(KIND_W1, '0, 16'sh8000, '0);
      send_word(KIND_W2, '0, 16'sh7fff, '0);
      send_word(KIND_PREDICT, '0, '0, '0);
      set_config(1, 0, 1, 0);
      send_word(KIND_PREDICT, '0, '0, '0);
      send_word(3'd5, 13'h1fff, 16'sh7fff, '0);
      send_word(3'd7, '0, '0, '0);
      send_word(KIND_LATENT, 13'd64, 16'sh1234, '0);
      send_word(KIND_W1, 13'h1fff, 16'sh1234, '0);
      send_word(KIND_W2, 13'd4096, 16'sh1234, '0);
      send_word(KIND_EMBED, 13'd256, 16'sh1234, '0);
      send_word(KIND_PREDICT, '0, '0, '0);
   endtask

   task automatic test_random_phase(int count);
      int k, r, ls, es, al, wv, A;
      logic [2:0] kind;
      int depth;
      wv = $urandom_range(0, 1);
      if (wv != 0) begin
         ls = $urandom_range(0, FILL_L);
         es = $urandom_range(0, FILL_E);
         al = es == 0 ? $urandom_range(0, 31) : $urandom_range(0, FILL_A);
      end else begin
         ls = $urandom_range(0, 127);
         es = $urandom_range(0, 31);
         al = $urandom_range(0, 31);
      end
      set_config(ls, es, al, wv);
      A = al > MAX_ACTIONS ? MAX_ACTIONS : al;
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            if (A > 0 && $urandom_range(0, 9) != 0)
               send_word(KIND_PREDICT, 13'($urandom), 16'($urandom),
                         8'($urandom_range(0, A - 1)));
            else
               send_word(KIND_PREDICT, 13'($urandom), 16'($urandom), 8'($urandom));
         end else if (r < 95) begin
            kind = 3'($urandom_range(0, 3));
            depth = kind == KIND_LATENT ? MAX_LATENT : kind == KIND_W1 ? W1_DEPTH :
                    kind == KIND_W2 ? W2_DEPTH : EMB_DEPTH;
            send_word(kind, 13'($urandom_range(0, 9) == 0 ? $urandom :
                                $urandom_range(0, depth - 1)),
                      16'($urandom), 8'($urandom));
         end else begin
            send_word(3'($urandom_range(5, 7)), 13'($urandom), 16'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      int p;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fill_stores();
      test_defaults_fallback();
      test_trained_small();
      test_clamps();
      test_zero_and_extremes();
      idle_on = 1'b0;
      test_random_phase(6);
      idle_on = 1'b1;
      for (p = 0; p < 2; p++) test_random_phase(4);
      drain();
      $display("covered %0d predicts, %0d result words: full-size fallback, a small trained net,",
               n_predicts, n_results);
      $display("bad actions, register clamps, zero vector, dropped kinds and writes");
      if (mismatches == 0) begin
         $display("tb_two_layer_mlp_latent_predictor: clean");
      end else begin
         $display("tb_two_layer_mlp_latent_predictor: errors");
      end
      $finish;
   end

endmodule
